// ===== src/hbc_pkg.sv =====
package hbc_pkg;

  // Widest index and bucket code that the parameter ranges allow
  localparam int unsigned IDX_W = 8;
  localparam int unsigned BKT_W = 4;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned STAMP_W = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN = 2'd2;
  localparam logic [1:0] CMD_UNPIN = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef enum logic [2:0] {
    WOP_CLAIM = 3'd0,
    WOP_HIT   = 3'd1,
    WOP_PIN   = 3'd2,
    WOP_DEC   = 3'd3,
    WOP_STAMP = 3'd4
  } wop_e;

  typedef struct packed {
    logic [7:0]       dev;
    logic [15:0]      blk;
    logic [BKT_W-1:0] bkt;
  } key_t;

  typedef struct packed {
    logic               en;
    wop_e               op;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         dev;
    logic [15:0]        blk;
    logic [BKT_W-1:0]   bkt;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  typedef struct packed {
    logic               hit_v;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit_sat;
    logic               hit_vld;
    logic               vic_v;
    logic [IDX_W-1:0]   vic_idx;
    logic [STAMP_W-1:0] vic_stamp;
    logic               fb_v;
    logic [BKT_W-1:0]   fb_bkt;
    logic [IDX_W-1:0]   fb_idx;
    logic [STAMP_W-1:0] fb_stamp;
  } scan_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [BKT_W-1:0] home;
  } view_t;

endpackage

// ===== src/hbc_cell.sv =====
module hbc_cell import hbc_pkg::*; #(
  parameter int unsigned MY_IDX = 0,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  key_t  key_i,
  input  wr_t   wr_i,
  input  scan_t scan_i,
  output scan_t scan_o,
  output view_t view_o
);

  localparam logic [BKT_W-1:0] HOME_RST = BKT_W'(MY_IDX % NUM_BUCKETS);
  localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

  logic [7:0]         tag_dev_q, tag_dev_d;
  logic [15:0]        tag_blk_q, tag_blk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [BKT_W-1:0]   home_q, home_d;
  logic               valid_q, valid_d;
  scan_t              scan_q, scan_d;

  always_comb begin
    logic free;
    free = (cnt_q == '0);
    scan_d = scan_i;
    if (!scan_i.hit_v && home_q == key_i.bkt && tag_dev_q == key_i.dev &&
        tag_blk_q == key_i.blk) begin
      scan_d.hit_v = 1'b1;
      scan_d.hit_idx = ME;
      scan_d.hit_sat = (cnt_q == COUNT_MAX);
      scan_d.hit_vld = valid_q;
    end
    // Strict compares keep the lower index on a stamp tie
    if (free && home_q == key_i.bkt &&
        (!scan_i.vic_v || stamp_q < scan_i.vic_stamp)) begin
      scan_d.vic_v = 1'b1;
      scan_d.vic_idx = ME;
      scan_d.vic_stamp = stamp_q;
    end
    if (free && home_q != key_i.bkt &&
        (!scan_i.fb_v || home_q < scan_i.fb_bkt ||
         (home_q == scan_i.fb_bkt && stamp_q < scan_i.fb_stamp))) begin
      scan_d.fb_v = 1'b1;
      scan_d.fb_bkt = home_q;
      scan_d.fb_idx = ME;
      scan_d.fb_stamp = stamp_q;
    end
  end

  always_comb begin
    tag_dev_d = tag_dev_q;
    tag_blk_d = tag_blk_q;
    cnt_d = cnt_q;
    stamp_d = stamp_q;
    home_d = home_q;
    valid_d = valid_q;
    if (wr_i.en && wr_i.idx == ME) begin
      case (wr_i.op)
        WOP_CLAIM: begin
          tag_dev_d = wr_i.dev;
          tag_blk_d = wr_i.blk;
          home_d = wr_i.bkt;
          cnt_d = CNT_W'(1);
          valid_d = 1'b1;
        end
        WOP_HIT: begin
          if (cnt_q != COUNT_MAX) cnt_d = cnt_q + CNT_W'(1);
          valid_d = 1'b1;
        end
        WOP_PIN: cnt_d = cnt_q + CNT_W'(1);
        WOP_DEC: cnt_d = cnt_q - CNT_W'(1);
        WOP_STAMP: begin
          cnt_d = cnt_q - CNT_W'(1);
          stamp_d = wr_i.stamp;
        end
        default: cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_dev_q <= '0;
      tag_blk_q <= '0;
      cnt_q <= '0;
      stamp_q <= '0;
      home_q <= HOME_RST;
      valid_q <= 1'b0;
      scan_q <= '0;
    end else begin
      tag_dev_q <= tag_dev_d;
      tag_blk_q <= tag_blk_d;
      cnt_q <= cnt_d;
      stamp_q <= stamp_d;
      home_q <= home_d;
      valid_q <= valid_d;
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;
  assign view_o = '{cnt: cnt_q, home: home_q};

endmodule

// ===== src/hashed_block_cache_lru.sv =====
// Hashed block-buffer tag manager.
// Requests enter on the s_axis channel: tuser carries the command (get,
// release, pin, unpin), tdata the device, block number and buffer index.
// Each request yields exactly one response on the m_axis channel: granted
// entry, disk-read flag, hit flag and status.
// One request is in work at a time. A get first reduces the (device,
// block) key to its bucket by a reciprocal multiplication, then waits
// while the search record ripples through the row of entry cells, then
// commits. Release, pin and unpin read the addressed cell and commit.
// A new request is taken only after the previous one has committed.
// The response waits in an output register; the next request is accepted
// while it waits, but its own commit holds until the receiver takes the
// earlier response.
// Reset clears all tags, counts, stamps, valid bits and bucket tick
// counters and returns every entry to bucket (index mod NUM_BUCKETS).
module hashed_block_cache_lru import hbc_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned NUM_BUCKETS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] device, [23:8] block_number, [28:24] buffer_index
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] granted_buffer, [5] needs_read, [6] was_hit, [8:7] status
  output logic [15:0] m_axis_tdata_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_SCAN = 5'b00100,
    S_READ = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  // Rounded-up reciprocal, exact for every 24-bit key
  localparam logic [28:0] RECIP = 29'((2**28 + NUM_BUCKETS - 1) / NUM_BUCKETS);

  state_e             state_q, state_d;
  logic [1:0]         cmd_q, cmd_d;
  key_t               key_q, key_d;
  logic [4:0]         idx_q, idx_d;
  logic [23:0]        hsh_q, hsh_d;
  logic [8:0]         cnt_q, cnt_d;
  view_t              sel_q, sel_d;
  logic [STAMP_W-1:0] ticks_q [NUM_BUCKETS];
  logic [STAMP_W-1:0] ticks_d [NUM_BUCKETS];
  logic               out_v_q, out_v_d;
  logic [15:0]        out_q, out_d;
  wr_t                wr;
  scan_t              chain [NUM_BUFFERS+1];
  view_t              views [NUM_BUFFERS];

  assign chain[0] = '0;

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    hbc_cell #(.MY_IDX(i), .NUM_BUCKETS(NUM_BUCKETS)) u_cell (
      .clk_i, .rst_ni,
      .key_i (key_q),
      .wr_i  (wr),
      .scan_i(chain[i]),
      .scan_o(chain[i+1]),
      .view_o(views[i])
    );
  end

  logic accept;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = out_q;

  always_comb begin
    logic [52:0]        prod;
    logic               in_range;
    scan_t              res;
    logic [STAMP_W-1:0] tick;
    logic [4:0]         gr;
    logic               rd;
    logic               hit;
    logic [1:0]         st;
    state_d = state_q;
    cmd_d = cmd_q;
    key_d = key_q;
    idx_d = idx_q;
    hsh_d = hsh_q;
    cnt_d = cnt_q;
    sel_d = sel_q;
    ticks_d = ticks_q;
    out_v_d = out_v_q && !m_axis_tready_i;
    out_d = out_q;
    wr = '0;
    wr.op = WOP_CLAIM;
    prod = 53'(hsh_q) * 53'(RECIP);
    in_range = ({4'b0, idx_q} < 9'(NUM_BUFFERS));
    res = chain[NUM_BUFFERS];
    tick = '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      if (sel_q.home == BKT_W'(b)) tick = ticks_q[b] + STAMP_W'(1);
    end
    gr = '0;
    rd = 1'b0;
    hit = 1'b0;
    st = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = s_axis_tuser_i;
          key_d.dev = s_axis_tdata_i[7:0];
          key_d.blk = s_axis_tdata_i[23:8];
          idx_d = s_axis_tdata_i[28:24];
          hsh_d = {s_axis_tdata_i[7:0], s_axis_tdata_i[23:8]};
          cnt_d = '0;
          state_d = (s_axis_tuser_i == CMD_GET) ? S_HASH : S_READ;
        end
      end
      S_HASH: begin
        // First form the quotient, then the remainder from the held key
        if (cnt_q == 9'd0) begin
          hsh_d = prod[51:28];
          cnt_d = 9'd1;
        end else begin
          key_d.bkt = BKT_W'({key_q.dev, key_q.blk} - hsh_q * 24'(NUM_BUCKETS));
          cnt_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Wait for the record to clear the last cell
        cnt_d = cnt_q + 9'd1;
        if (cnt_q == 9'(NUM_BUFFERS)) state_d = S_RESP;
      end
      S_READ: begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if ({4'b0, idx_q} == 9'(i)) sel_d = views[i];
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_v_q || m_axis_tready_i) begin
          wr.dev = key_q.dev;
          wr.blk = key_q.blk;
          wr.bkt = key_q.bkt;
          if (cmd_q == CMD_GET) begin
            if (res.hit_v) begin
              wr.en = 1'b1;
              wr.op = WOP_HIT;
              wr.idx = res.hit_idx;
              gr = res.hit_idx[4:0];
              rd = !res.hit_vld;
              hit = 1'b1;
              st = res.hit_sat ? ST_SATURATED : ST_OK;
            end else if (res.vic_v || res.fb_v) begin
              wr.en = 1'b1;
              wr.op = WOP_CLAIM;
              wr.idx = res.vic_v ? res.vic_idx : res.fb_idx;
              gr = wr.idx[4:0];
              rd = 1'b1;
            end else begin
              st = ST_NO_FREE;
            end
          end else begin
            gr = idx_q;
            wr.idx = IDX_W'(idx_q);
            if (in_range) begin
              if (cmd_q == CMD_PIN) begin
                if (sel_q.cnt == COUNT_MAX) st = ST_SATURATED;
                else begin
                  wr.en = 1'b1;
                  wr.op = WOP_PIN;
                end
              end else if (sel_q.cnt == '0) begin
                st = ST_UNDERFLOW;
              end else if (cmd_q == CMD_RELEASE && sel_q.cnt == CNT_W'(1)) begin
                wr.en = 1'b1;
                wr.op = WOP_STAMP;
                wr.stamp = tick;
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                  if (sel_q.home == BKT_W'(b)) ticks_d[b] = tick;
                end
              end else begin
                wr.en = 1'b1;
                wr.op = WOP_DEC;
              end
            end
          end
          out_d = {7'b0, st, hit, rd, gr};
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      cnt_q <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) ticks_q[b] <= '0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      cnt_q <= cnt_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    idx_q <= idx_d;
    hsh_q <= hsh_d;
    sel_q <= sel_d;
    out_q <= out_d;
  end

endmodule

// ===== src/hbc_checker.sv =====
module hbc_checker import hbc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("response dropped or changed while stalled");

  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[8:7] == ST_NO_FREE |-> m_axis_tdata_o[6:0] == 7'd0)
    else $error("no-free response carries a grant");

  a_hit_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6] |->
      (m_axis_tdata_o[8:7] == ST_OK || m_axis_tdata_o[8:7] == ST_SATURATED))
    else $error("hit with bad status");

  a_uflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[8:7] == ST_UNDERFLOW |-> m_axis_tdata_o[6:5] == 2'b00)
    else $error("underflow response flags a get");

endmodule

bind hashed_block_cache_lru hbc_checker u_hbc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o)
);
